// ===== hw/rtl/ilss_pkg.sv =====
// Package for the IR learn/send sequencer: codes, widths, state and result types.
// No dependencies; used by the interfaces, the step logic, the top level and the checker.

package ilss_pkg;

   localparam int COUNTER_WIDTH = 16;
   localparam int LEARNED_BYTES = 230;

   localparam int KIND_W   = 3;
   localparam int ACTION_W = 4;
   localparam int MODE_W   = 3;
   localparam int RESULT_W = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef logic [COUNTER_WIDTH-1:0] count_type;
   typedef logic [7:0]               byte_type;
   typedef logic [KIND_W-1:0]        kind_type;
   typedef logic [ACTION_W-1:0]      action_type;
   typedef logic [MODE_W-1:0]        mode_type;
   typedef logic [RESULT_W-1:0]      result_code_type;

   // input kinds
   localparam kind_type KIND_TICK  = 3'd0;
   localparam kind_type KIND_LEARN = 3'd1;
   localparam kind_type KIND_SEND  = 3'd2;
   localparam kind_type KIND_STOP  = 3'd3;
   localparam kind_type KIND_DATA  = 3'd4;

   // actions
   localparam action_type ACT_NONE      = 4'd0;
   localparam action_type ACT_LEARN     = 4'd1;
   localparam action_type ACT_READ      = 4'd2;
   localparam action_type ACT_STORE     = 4'd3;
   localparam action_type ACT_SEND      = 4'd4;
   localparam action_type ACT_RST_ON    = 4'd5;
   localparam action_type ACT_RST_OFF   = 4'd6;
   localparam action_type ACT_BEEP_OK   = 4'd7;
   localparam action_type ACT_BEEP_FAIL = 4'd8;

   // sequencer modes
   localparam mode_type MODE_FREE    = 3'd0;
   localparam mode_type MODE_LSTBY   = 3'd1;
   localparam mode_type MODE_LEARN   = 3'd2;
   localparam mode_type MODE_COLLECT = 3'd3;
   localparam mode_type MODE_SSTBY   = 3'd4;
   localparam mode_type MODE_SEND    = 3'd5;
   localparam mode_type MODE_HOLD    = 3'd6;

   // result codes
   localparam result_code_type RES_NONE    = 2'd0;
   localparam result_code_type RES_LEARNED = 2'd1;
   localparam result_code_type RES_SENT    = 2'd2;

   // csr indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STANDBY_TIMEOUT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STANDBY_RETRIES  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_TIMEOUT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEND_SETTLE_TIME = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_HOLD_TIME  = 3'd4;

   // frame layout
   localparam byte_type FRAME_HEAD0   = 8'h30;
   localparam byte_type FRAME_HEAD1   = 8'h03;
   localparam byte_type SUM_SEED      = 8'h33;
   localparam byte_type FRAME_FULL    = 8'(LEARNED_BYTES);
   localparam byte_type LAST_DATA_POS = 8'(LEARNED_BYTES - 1);
   localparam byte_type SUM_INDEX     = 8'(LEARNED_BYTES + 1);

   typedef struct packed {
      logic [15:0] standby_timeout;
      logic [7:0]  standby_retries;
      logic [15:0] learn_timeout;
      logic [15:0] send_settle_time;
      logic [15:0] reset_hold_time;
   } cfg_type;

   typedef struct packed {
      mode_type        mode;
      count_type       tick_count;
      logic [7:0]      retries_left;
      byte_type        current_slot;
      byte_type        byte_count;
      byte_type        running_sum;
      result_code_type last_result;
   } state_type;

   typedef struct packed {
      action_type action;
      byte_type   frame_byte;
      byte_type   frame_index;
   } beat_type;

   typedef struct packed {
      logic [1:0] count;
      beat_type   first;
      beat_type   second;
   } step_out_type;

endpackage

// ===== hw/rtl/ilss_req_if.sv =====
// Request channel interface: valid/ready plus one input item.
// Depends on ilss_pkg.

interface ilss_req_if;
   logic                        valid;
   logic                        ready;
   logic [ilss_pkg::KIND_W-1:0] kind;
   logic [7:0]                  slot;
   logic                        busy_req;
   logic [7:0]                  data_byte;
   logic                        report_window_open;

   modport source (output valid, kind, slot, busy_req, data_byte, report_window_open,
                   input ready);
   modport sink   (input valid, kind, slot, busy_req, data_byte, report_window_open,
                   output ready);
endinterface

// ===== hw/rtl/ilss_rsp_if.sv =====
// Response channel interface: valid/ready plus one result item.
// Depends on ilss_pkg.

interface ilss_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ilss_pkg::ACTION_W-1:0] action;
   logic [7:0]                    frame_byte;
   logic [7:0]                    frame_index;
   logic [7:0]                    target_slot;
   logic [ilss_pkg::RESULT_W-1:0] result_code;
   logic [ilss_pkg::MODE_W-1:0]   machine_state;
   logic                          last;

   modport source (output valid, action, frame_byte, frame_index, target_slot,
                   result_code, machine_state, last, input ready);
   modport sink   (input valid, action, frame_byte, frame_index, target_slot,
                   result_code, machine_state, last, output ready);
endinterface

// ===== hw/rtl/ilss_step.sv =====
// Next-state and action logic for one request beat of the sequencer.
// Depends on ilss_pkg; pure combinational, instanced by the top level.

module ilss_step (
   input  ilss_pkg::state_type    cur,
   input  ilss_pkg::cfg_type      cfg,
   input  ilss_pkg::kind_type     kind,
   input  logic [7:0]             slot,
   input  logic                   busy,
   input  logic [7:0]             data_byte,
   input  logic                   window_open,
   output ilss_pkg::state_type    nxt,
   output ilss_pkg::step_out_type res
);
   import ilss_pkg::*;

   count_type tick_dec;
   byte_type  sum_new;
   logic      in_hold;

   assign tick_dec = (cur.tick_count != '0) ? count_type'(cur.tick_count - 1'b1) : '0;
   assign sum_new  = byte_type'(cur.running_sum + data_byte);
   assign in_hold  = (cur.mode == MODE_HOLD);

   always_comb begin
      nxt = cur;
      res = '0;
      unique case (kind)
         KIND_TICK: begin
            if (!window_open) nxt.last_result = RES_NONE;
            nxt.tick_count = tick_dec;
            unique case (cur.mode)
               MODE_FREE: begin
               end
               MODE_LSTBY: begin
                  if (cur.retries_left == '0) begin
                     nxt.mode = MODE_FREE;
                  end else if (!busy) begin
                     nxt.mode       = MODE_LEARN;
                     nxt.tick_count = count_type'(cfg.learn_timeout);
                  end else if (tick_dec == '0) begin
                     res.count          = 2'd1;
                     res.first.action   = ACT_LEARN;
                     nxt.tick_count     = count_type'(cfg.standby_timeout);
                     nxt.retries_left   = 8'(cur.retries_left - 1'b1);
                  end
               end
               MODE_LEARN: begin
                  if (tick_dec != '0) begin
                     if (busy) begin
                        res.count        = 2'd1;
                        res.first.action = ACT_READ;
                        nxt.mode         = MODE_COLLECT;
                        nxt.byte_count   = '0;
                        nxt.running_sum  = SUM_SEED;
                     end
                  end else begin
                     // learning timed out: fail beep, then hold the chip in reset
                     res.count         = 2'd2;
                     res.first.action  = ACT_BEEP_FAIL;
                     res.second.action = ACT_RST_ON;
                     nxt.mode          = MODE_HOLD;
                     nxt.tick_count    = count_type'(cfg.reset_hold_time);
                     nxt.retries_left  = '0;
                     nxt.current_slot  = '0;
                     nxt.byte_count    = '0;
                     nxt.running_sum   = '0;
                  end
               end
               MODE_COLLECT: begin
                  if (cur.byte_count >= FRAME_FULL) begin
                     res.count        = 2'd1;
                     res.first.action = ACT_BEEP_OK;
                     nxt.mode         = MODE_FREE;
                     nxt.last_result  = RES_LEARNED;
                  end
               end
               MODE_SSTBY: begin
                  if (tick_dec == '0) nxt.mode = MODE_SEND;
               end
               MODE_SEND: begin
                  res.count        = 2'd1;
                  res.first.action = ACT_SEND;
                  nxt.mode         = MODE_FREE;
                  nxt.last_result  = RES_SENT;
               end
               MODE_HOLD: begin
                  if (tick_dec == '0) begin
                     res.count        = 2'd1;
                     res.first.action = ACT_RST_OFF;
                     nxt.mode         = MODE_FREE;
                  end
               end
               default: nxt.mode = MODE_FREE;
            endcase
         end
         KIND_LEARN: begin
            if (cur.mode != MODE_LEARN && cur.mode != MODE_COLLECT) begin
               nxt.mode         = MODE_LSTBY;
               nxt.tick_count   = count_type'(cfg.standby_timeout);
               nxt.retries_left = cfg.standby_retries;
               nxt.current_slot = slot;
               if (in_hold) begin
                  res.count         = 2'd2;
                  res.first.action  = ACT_RST_OFF;
                  res.second.action = ACT_LEARN;
               end else begin
                  res.count        = 2'd1;
                  res.first.action = ACT_LEARN;
               end
            end
         end
         KIND_SEND: begin
            if (in_hold) begin
               res.count        = 2'd1;
               res.first.action = ACT_RST_OFF;
            end
            nxt.mode         = MODE_SSTBY;
            nxt.tick_count   = count_type'(cfg.send_settle_time);
            nxt.current_slot = slot;
            nxt.byte_count   = '0;
         end
         KIND_STOP: begin
            res.count        = 2'd1;
            res.first.action = ACT_RST_ON;
            nxt.mode         = MODE_HOLD;
            nxt.tick_count   = count_type'(cfg.reset_hold_time);
            nxt.retries_left = '0;
            nxt.current_slot = '0;
            nxt.byte_count   = '0;
            nxt.running_sum  = '0;
         end
         KIND_DATA: begin
            if (cur.mode == MODE_COLLECT && cur.byte_count < FRAME_FULL) begin
               nxt.byte_count = byte_type'(cur.byte_count + 1'b1);
               if (cur.byte_count == '0) begin
                  // first learned byte is replaced by the frame header
                  res.count             = 2'd2;
                  res.first.action      = ACT_STORE;
                  res.first.frame_byte  = FRAME_HEAD0;
                  res.first.frame_index = 8'd0;
                  res.second.action     = ACT_STORE;
                  res.second.frame_byte = FRAME_HEAD1;
                  res.second.frame_index = 8'd1;
               end else begin
                  nxt.running_sum       = sum_new;
                  res.count             = 2'd1;
                  res.first.action      = ACT_STORE;
                  res.first.frame_byte  = data_byte;
                  res.first.frame_index = byte_type'(cur.byte_count + 1'b1);
                  if (cur.byte_count == LAST_DATA_POS) begin
                     res.count              = 2'd2;
                     res.second.action      = ACT_STORE;
                     res.second.frame_byte  = sum_new;
                     res.second.frame_index = SUM_INDEX;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      if (res.count == 2'd0) begin
         res.count        = 2'd1;
         res.first.action = ACT_NONE;
      end
   end

endmodule

// ===== hw/rtl/ir_learn_send_sequencer.sv =====
// Top level of the IR learn/send sequencer: csr bank, state register, result buffer.
// Depends on ilss_pkg, ilss_req_if, ilss_rsp_if and ilss_step.
//
//   channel   dir  handshake            payload
//   req_bus   in   valid/ready          kind, slot, busy_req, data_byte, report_window_open
//   rsp_bus   out  valid/ready          action, frame_byte, frame_index, target_slot,
//                                       result_code, machine_state, last
//   csr_*     in   csr_we (no stall)    csr_index, csr_wdata
//
// A request beat is processed in the cycle it is accepted; its results show on
// rsp_bus from the next cycle. One request per cycle when rsp_bus does not stall and each
// gives one result; a request giving two results fills the two-entry result buffer.
// Reset (synchronous) restores csr defaults and the free state; no clearing pass.
// A stalled rsp_bus holds the buffer; req_bus.ready needs it empty or its lone entry taken.

module ir_learn_send_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   ilss_req_if.sink                          req_bus,
   ilss_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [ilss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ilss_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ilss_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   state_type    state_ff, state_in;
   step_out_type step_res;

   logic [1:0]   cnt_ff, cnt_in;
   beat_type     head_ff, head_in;
   beat_type     tail_ff, tail_in;
   byte_type     slot_ff, slot_in;
   result_code_type code_ff, code_in;
   mode_type     mode_ff, mode_in;

   logic         req_fire;
   logic         rsp_fire;

   ilss_step u_step (
      .cur         (state_ff),
      .cfg         (cfg_ff),
      .kind        (req_bus.kind),
      .slot        (req_bus.slot),
      .busy        (req_bus.busy_req),
      .data_byte   (req_bus.data_byte),
      .window_open (req_bus.report_window_open),
      .nxt         (state_in),
      .res         (step_res)
   );

   assign rsp_fire      = rsp_bus.valid && rsp_bus.ready;
   assign req_bus.ready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_bus.ready);
   assign req_fire      = req_bus.valid && req_bus.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_STANDBY_TIMEOUT:  cfg_in.standby_timeout  = csr_wdata;
            CSR_STANDBY_RETRIES:  cfg_in.standby_retries  = csr_wdata[7:0];
            CSR_LEARN_TIMEOUT:    cfg_in.learn_timeout    = csr_wdata;
            CSR_SEND_SETTLE_TIME: cfg_in.send_settle_time = csr_wdata;
            CSR_RESET_HOLD_TIME:  cfg_in.reset_hold_time  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cnt_in  = cnt_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      slot_in = slot_ff;
      code_in = code_ff;
      mode_in = mode_ff;
      if (req_fire) begin
         cnt_in  = step_res.count;
         head_in = step_res.first;
         tail_in = step_res.second;
         slot_in = state_in.current_slot;
         code_in = state_in.last_result;
         mode_in = state_in.mode;
      end else if (rsp_fire) begin
         // second beat of a pair moves up
         cnt_in  = 2'(cnt_ff - 1'b1);
         head_in = tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.standby_timeout  <= 16'd200;
         cfg_ff.standby_retries  <= 8'd3;
         cfg_ff.learn_timeout    <= 16'd3000;
         cfg_ff.send_settle_time <= 16'd20;
         cfg_ff.reset_hold_time  <= 16'd50;
         state_ff.mode           <= MODE_FREE;
         state_ff.tick_count     <= '0;
         state_ff.retries_left   <= '0;
         state_ff.current_slot   <= '0;
         state_ff.byte_count     <= '0;
         state_ff.running_sum    <= '0;
         state_ff.last_result    <= RES_NONE;
         cnt_ff                  <= 2'd0;
      end else begin
         cfg_ff <= cfg_in;
         if (req_fire) state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
      slot_ff <= slot_in;
      code_ff <= code_in;
      mode_ff <= mode_in;
   end

   assign rsp_bus.valid         = (cnt_ff != 2'd0);
   assign rsp_bus.action        = head_ff.action;
   assign rsp_bus.frame_byte    = head_ff.frame_byte;
   assign rsp_bus.frame_index   = head_ff.frame_index;
   assign rsp_bus.target_slot   = slot_ff;
   assign rsp_bus.result_code   = code_ff;
   assign rsp_bus.machine_state = mode_ff;
   assign rsp_bus.last          = (cnt_ff == 2'd1);

endmodule

// ===== hw/rtl/ilss_checker.sv =====
// Port-level checker for the IR learn/send sequencer, bound to the top level.
// Depends on ilss_pkg and ir_learn_send_sequencer.

module ilss_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [ilss_pkg::ACTION_W-1:0]   action,
   input logic [7:0]                      frame_byte,
   input logic [7:0]                      frame_index,
   input logic [7:0]                      target_slot,
   input logic [ilss_pkg::MODE_W-1:0]     machine_state,
   input logic                            last
);
   import ilss_pkg::*;

   // stalled beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(action) && $stable(last))
      else $error("rsp beat changed while stalled");

   // store beats only come out of collecting
   a_store_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && action == ACT_STORE |-> machine_state == MODE_COLLECT)
      else $error("store beat outside collecting");

   // frame fields are zero unless storing
   a_frame_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && action != ACT_STORE |-> frame_byte == 8'd0 && frame_index == 8'd0)
      else $error("frame fields set on non-store beat");

   // fail beep always leads a reset-on beat of the same request
   a_fail_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && action == ACT_BEEP_FAIL |->
         !last ##1 (rsp_valid && action == ACT_RST_ON && last))
      else $error("fail beep not followed by reset on");

   // reset on always lands in reset hold with the slot cleared
   a_rst_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && action == ACT_RST_ON |-> machine_state == MODE_HOLD && target_slot == 8'd0)
      else $error("reset on beat with wrong state");

endmodule

bind ir_learn_send_sequencer ilss_checker u_ilss_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .action        (rsp_bus.action),
   .frame_byte    (rsp_bus.frame_byte),
   .frame_index   (rsp_bus.frame_index),
   .target_slot   (rsp_bus.target_slot),
   .machine_state (rsp_bus.machine_state),
   .last          (rsp_bus.last)
);
